### rtl/core/grwi_pkg.sv
// Shared types, command codes and constants for the grid ray wall intersection block.
`default_nettype none
package grwi_pkg;

    // opcodes carried in the input tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_HCAST = 2'd1;
    localparam logic [1:0] OP_VCAST = 2'd2;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TOL    = 2'd2;

    // controller to datapath commands
    typedef logic [3:0] cmd_t;
    localparam cmd_t CMD_NONE     = 4'd0;
    localparam cmd_t CMD_LOAD     = 4'd1;
    localparam cmd_t CMD_CLEAR    = 4'd2;
    localparam cmd_t CMD_CORDIC   = 4'd3;
    localparam cmd_t CMD_MUL      = 4'd4;
    localparam cmd_t CMD_DIV1_LD  = 4'd5;
    localparam cmd_t CMD_DIV_STEP = 4'd6;
    localparam cmd_t CMD_DIV2_LD  = 4'd7;
    localparam cmd_t CMD_POS      = 4'd8;
    localparam cmd_t CMD_CELL_A   = 4'd9;
    localparam cmd_t CMD_CELL_B   = 4'd10;
    localparam cmd_t CMD_HIT      = 4'd11;
    localparam cmd_t CMD_ADV      = 4'd12;
    localparam cmd_t CMD_OUT      = 4'd13;

    typedef struct packed {
        logic nohit;
        logic outside;
        logic wall;
        logic out_full;
    } status_t;

    localparam int CORDIC_STEPS = 16;
    localparam int DIV_W        = 48;   // divider numerator / quotient width
    localparam int DEN_W        = 20;   // divisor magnitude width
    localparam int CW           = 20;   // CORDIC x/y width, signed
    localparam int ZW           = 25;   // CORDIC angle width, signed
    localparam int POS_W        = 48;   // walk position width, signed

    localparam int QUARTER_TURN = 11520;
    localparam int HALF_TURN    = 23040;
    localparam int CORDIC_GAIN  = 39797;
    localparam int COORD_MAX    = 1048575;

    function automatic logic signed [ZW-1:0] atan_q15(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            4'd0:    r = 25'sd1474560;
            4'd1:    r = 25'sd870484;
            4'd2:    r = 25'sd459940;
            4'd3:    r = 25'sd233473;
            4'd4:    r = 25'sd117189;
            4'd5:    r = 25'sd58652;
            4'd6:    r = 25'sd29333;
            4'd7:    r = 25'sd14667;
            4'd8:    r = 25'sd7334;
            4'd9:    r = 25'sd3667;
            4'd10:   r = 25'sd1833;
            4'd11:   r = 25'sd917;
            4'd12:   r = 25'sd458;
            4'd13:   r = 25'sd229;
            4'd14:   r = 25'sd115;
            default: r = 25'sd57;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/grwi_ctrl.sv
// Controller state machine: sequences map clearing, writes and the cast steps.
`default_nettype none
module grwi_ctrl #(
    parameter int MAP_CELLS = 4096,
    localparam int ADDR_W = $clog2(MAP_CELLS),
    localparam int CNT_W  = (ADDR_W > 6) ? ADDR_W : 6
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [1:0]             in_opcode,
    output logic                        in_ready,
    input  wire grwi_pkg::status_t      status,
    output grwi_pkg::cmd_t              cmd,
    output logic [CNT_W-1:0]            cnt
);
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CORDIC  = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd3;
    localparam logic [3:0] S_DIV1_LD = 4'd4;
    localparam logic [3:0] S_DIV1    = 4'd5;
    localparam logic [3:0] S_DIV2_LD = 4'd6;
    localparam logic [3:0] S_DIV2    = 4'd7;
    localparam logic [3:0] S_POS     = 4'd8;
    localparam logic [3:0] S_CELL_A  = 4'd9;
    localparam logic [3:0] S_CELL_B  = 4'd10;
    localparam logic [3:0] S_CELL_C  = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign cnt = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = grwi_pkg::CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd      = grwi_pkg::CMD_CLEAR;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAP_CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = grwi_pkg::CMD_LOAD;
                    if (in_opcode == grwi_pkg::OP_HCAST || in_opcode == grwi_pkg::OP_VCAST)
                    begin
                        cnt_next   = '0;
                        state_next = S_CORDIC;
                    end
                end
            end
            S_CORDIC:
            begin
                cmd      = grwi_pkg::CMD_CORDIC;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(grwi_pkg::CORDIC_STEPS - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd        = grwi_pkg::CMD_MUL;
                state_next = status.nohit ? S_OUT : S_DIV1_LD;
            end
            S_DIV1_LD:
            begin
                cmd        = grwi_pkg::CMD_DIV1_LD;
                cnt_next   = '0;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd      = grwi_pkg::CMD_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(grwi_pkg::DIV_W - 1))
                    state_next = S_DIV2_LD;
            end
            S_DIV2_LD:
            begin
                cmd        = grwi_pkg::CMD_DIV2_LD;
                cnt_next   = '0;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd      = grwi_pkg::CMD_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(grwi_pkg::DIV_W - 1))
                    state_next = S_POS;
            end
            S_POS:
            begin
                cmd        = grwi_pkg::CMD_POS;
                state_next = S_CELL_A;
            end
            S_CELL_A:
            begin
                cmd        = grwi_pkg::CMD_CELL_A;
                state_next = S_CELL_B;
            end
            S_CELL_B:
            begin
                cmd        = grwi_pkg::CMD_CELL_B;
                state_next = S_CELL_C;
            end
            S_CELL_C:
            begin
                if (status.outside)
                    state_next = S_OUT;
                else if (status.wall)
                begin
                    cmd        = grwi_pkg::CMD_HIT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd        = grwi_pkg::CMD_ADV;
                    state_next = S_CELL_A;
                end
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd        = grwi_pkg::CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/grwi_dp.sv
// Datapath: wall map, CORDIC, shared divider, grid walk and result register.
`default_nettype none
module grwi_dp #(
    parameter int MAP_CELLS  = 4096,
    parameter int CELL_UNITS = 64,
    localparam int ADDR_W = $clog2(MAP_CELLS),
    localparam int CNT_W  = (ADDR_W > 6) ? ADDR_W : 6
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire grwi_pkg::cmd_t         cmd,
    input  wire logic [CNT_W-1:0]       cnt,
    output grwi_pkg::status_t           status,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_addr,
    input  wire logic [10:0]            cfg_wdata,
    input  wire logic [1:0]             opcode,
    input  wire logic [11:0]            cell_index,
    input  wire logic                   cell_is_wall,
    input  wire logic signed [15:0]     ray_angle,
    input  wire logic signed [20:0]     start_line,
    input  wire logic [19:0]            player_x,
    input  wire logic [19:0]            player_y,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        out_hit,
    output logic signed [20:0]          out_hit_x,
    output logic signed [20:0]          out_hit_y
);
    localparam int LINE   = CELL_UNITS * 256;
    localparam int LOOK_W = $clog2(LINE * 128);
    localparam int CW     = grwi_pkg::CW;
    localparam int ZW     = grwi_pkg::ZW;
    localparam int POS_W  = grwi_pkg::POS_W;
    localparam int DIV_W  = grwi_pkg::DIV_W;
    localparam int DEN_W  = grwi_pkg::DEN_W;

    // configuration
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    logic [10:0] tol_reg;

    // wall map
    logic mem [MAP_CELLS];
    logic rdata_reg;

    // cast context
    logic                    horiz_reg;
    logic                    band_reg;
    logic signed [20:0]      line_reg;
    logic [19:0]             px_reg;
    logic [19:0]             py_reg;
    logic                    flip_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg;
    logic signed [ZW-1:0]    z_reg;
    logic signed [41:0]      prod_reg;
    logic [DIV_W-1:0]        num_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    qneg_reg;
    logic signed [POS_W-1:0] q1_reg;
    logic signed [POS_W-1:0] x_reg, y_reg, xs_reg, ys_reg;
    logic [6:0]              col_reg, row_reg;
    logic                    out_a_reg;
    logic                    outside_reg;
    logic                    res_hit_reg;
    logic                    out_valid_reg;

    function automatic logic in_band(input logic signed [17:0] d, input logic [10:0] tol);
        logic [17:0] m;
        m = d[17] ? 18'(-d) : 18'(d);
        return m < {7'd0, tol};
    endfunction

    // column or row of an in-range coordinate: restoring compare against multiples of LINE
    function automatic logic [6:0] cell_of(input logic [LOOK_W-1:0] v);
        logic [6:0] acc;
        logic [6:0] trial;
        acc = '0;
        for (int k = 6; k >= 0; k--)
        begin
            trial = acc | (7'd1 << k);
            if (v >= LOOK_W'(trial) * LOOK_W'(LINE))
                acc = trial;
        end
        return acc;
    endfunction

    function automatic logic signed [20:0] sat_coord(input logic signed [POS_W-1:0] v);
        return (v > POS_W'(grwi_pkg::COORD_MAX)) ? 21'(grwi_pkg::COORD_MAX) : v[20:0];
    endfunction

    // angle fold and band test on the incoming item
    logic signed [16:0] a17, af;
    logic               fold;
    logic signed [17:0] a18;
    logic               band;

    always_comb
    begin
        a17  = {ray_angle[15], ray_angle};
        af   = a17;
        fold = 1'b0;
        if (a17 > 17'sd11520)
        begin
            af   = a17 - 17'sd23040;
            fold = 1'b1;
        end
        else if (a17 < -17'sd11520)
        begin
            af   = a17 + 17'sd23040;
            fold = 1'b1;
        end
        a18 = {a17[16], a17};
        if (opcode == grwi_pkg::OP_HCAST)
            band = in_band(a18 - 18'sd11520, tol_reg) || in_band(a18 + 18'sd11520, tol_reg);
        else
            band = in_band(a18, tol_reg) || in_band(a18 - 18'sd23040, tol_reg)
                || in_band(a18 + 18'sd23040, tol_reg);
    end

    // sine and cosine after unfolding
    logic signed [CW-1:0] s_val, c_val;
    logic [DEN_W-1:0]     s_mag, c_mag;
    logic                 c_pos;
    logic                 nohit;

    always_comb
    begin
        s_val = flip_reg ? -cy_reg : cy_reg;
        c_val = flip_reg ? -cx_reg : cx_reg;
        s_mag = s_val[CW-1] ? DEN_W'(-s_val) : DEN_W'(s_val);
        c_mag = c_val[CW-1] ? DEN_W'(-c_val) : DEN_W'(c_val);
        c_pos = !c_val[CW-1] && (c_val != '0);
        nohit = band_reg || (horiz_reg ? (c_val == '0) : (s_val == '0));
    end

    // CORDIC rotation terms
    logic [3:0]           sh;
    logic signed [CW-1:0] x_sh, y_sh;
    logic signed [ZW-1:0] at;

    assign sh   = cnt[3:0];
    assign x_sh = cx_reg >>> sh;
    assign y_sh = cy_reg >>> sh;
    assign at   = grwi_pkg::atan_q15(sh);

    // multiplier operands
    logic signed [21:0]   diff;
    logic signed [CW-1:0] mul_b;
    logic [41:0]          prod_mag;

    always_comb
    begin
        if (horiz_reg)
        begin
            diff  = $signed({2'b00, py_reg}) - $signed({line_reg[20], line_reg});
            mul_b = s_val;
        end
        else
        begin
            diff  = $signed({2'b00, px_reg}) - $signed({line_reg[20], line_reg});
            mul_b = c_val;
        end
        prod_mag = prod_reg[41] ? 42'(-prod_reg) : 42'(prod_reg);
    end

    // restoring divider step
    logic [DEN_W:0] rem_sh;
    logic           qbit;

    assign rem_sh = {rem_reg, num_reg[DIV_W-1]};
    assign qbit   = rem_sh >= {1'b0, den_reg};

    // grid walk lookup
    logic [POS_W-1:0]        wbound, hbound;
    logic                    out_a;
    logic [13:0]             idx;
    logic signed [POS_W-1:0] step;
    logic signed [POS_W-1:0] line_pos;

    always_comb
    begin
        wbound   = POS_W'(width_reg) * POS_W'(LINE);
        hbound   = POS_W'(height_reg) * POS_W'(LINE);
        out_a    = x_reg[POS_W-1] || y_reg[POS_W-1]
                || ($unsigned(x_reg) >= wbound) || ($unsigned(y_reg) >= hbound);
        idx      = 14'(row_reg) * 14'(width_reg) + 14'(col_reg);
        step     = $signed(num_reg);
        line_pos = POS_W'(line_reg);
    end

    // memory write port: clearing pass or a write item
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(cell_index);
        mem_wdata = cell_is_wall;
        if (cmd == grwi_pkg::CMD_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt[ADDR_W-1:0];
            mem_wdata = 1'b0;
        end
        else if (cmd == grwi_pkg::CMD_LOAD && opcode == grwi_pkg::OP_WRITE
                 && 17'(cell_index) < 17'(MAP_CELLS))
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd == grwi_pkg::CMD_CELL_B)
            rdata_reg <= mem[ADDR_W'(idx)];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            grwi_pkg::CMD_LOAD:
            begin
                horiz_reg <= (opcode == grwi_pkg::OP_HCAST);
                band_reg  <= band;
                line_reg  <= start_line;
                px_reg    <= player_x;
                py_reg    <= player_y;
                flip_reg  <= fold;
                cx_reg    <= CW'(grwi_pkg::CORDIC_GAIN);
                cy_reg    <= '0;
                z_reg     <= {af, 8'd0};
            end
            grwi_pkg::CMD_CORDIC:
            begin
                if (!z_reg[ZW-1])
                begin
                    cx_reg <= cx_reg - y_sh;
                    cy_reg <= cy_reg + x_sh;
                    z_reg  <= z_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + y_sh;
                    cy_reg <= cy_reg - x_sh;
                    z_reg  <= z_reg + at;
                end
            end
            grwi_pkg::CMD_MUL:
            begin
                prod_reg    <= diff * mul_b;
                res_hit_reg <= 1'b0;
            end
            grwi_pkg::CMD_DIV1_LD:
            begin
                num_reg  <= DIV_W'(prod_mag);
                rem_reg  <= '0;
                den_reg  <= horiz_reg ? c_mag : s_mag;
                qneg_reg <= prod_reg[41] ^ (horiz_reg ? c_val[CW-1] : s_val[CW-1]);
            end
            grwi_pkg::CMD_DIV_STEP:
            begin
                rem_reg <= qbit ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
                num_reg <= {num_reg[DIV_W-2:0], qbit};
            end
            grwi_pkg::CMD_DIV2_LD:
            begin
                q1_reg  <= qneg_reg ? -$signed(num_reg) : $signed(num_reg);
                num_reg <= DIV_W'(LINE) * DIV_W'(horiz_reg ? s_mag : c_mag);
                rem_reg <= '0;
            end
            grwi_pkg::CMD_POS:
            begin
                if (horiz_reg)
                begin
                    y_reg  <= line_pos;
                    x_reg  <= $signed(POS_W'(px_reg)) + q1_reg;
                    ys_reg <= c_pos ? -POS_W'(LINE) : POS_W'(LINE);
                    xs_reg <= s_val[CW-1] ? -step : step;
                end
                else
                begin
                    x_reg  <= line_pos;
                    y_reg  <= $signed(POS_W'(py_reg)) + q1_reg;
                    xs_reg <= s_val[CW-1] ? -POS_W'(LINE) : POS_W'(LINE);
                    ys_reg <= c_pos ? -step : step;
                end
            end
            grwi_pkg::CMD_CELL_A:
            begin
                out_a_reg <= out_a;
                col_reg   <= cell_of(x_reg[LOOK_W-1:0]);
                row_reg   <= cell_of(y_reg[LOOK_W-1:0]);
            end
            grwi_pkg::CMD_CELL_B:
                outside_reg <= out_a_reg || (17'(idx) >= 17'(MAP_CELLS));
            grwi_pkg::CMD_HIT:
                res_hit_reg <= 1'b1;
            grwi_pkg::CMD_ADV:
            begin
                x_reg <= x_reg + xs_reg;
                y_reg <= y_reg + ys_reg;
            end
            grwi_pkg::CMD_OUT:
            begin
                out_hit   <= res_hit_reg;
                out_hit_x <= res_hit_reg ? sat_coord(x_reg) : '0;
                out_hit_y <= res_hit_reg ? sat_coord(y_reg) : '0;
            end
            default:
            begin
            end
        endcase
    end

    // configuration and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 7'd64;
            height_reg    <= 7'd64;
            tol_reg       <= 11'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    grwi_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[6:0];
                    grwi_pkg::REG_HEIGHT: height_reg <= cfg_wdata[6:0];
                    grwi_pkg::REG_TOL:    tol_reg    <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd == grwi_pkg::CMD_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.nohit    = nohit;
    assign status.outside  = outside_reg;
    assign status.wall     = rdata_reg;
    assign status.out_full = out_valid_reg && !out_ready;

endmodule
`default_nettype wire

### rtl/core/grid_ray_wall_intersection.sv
// Top level of the grid ray wall intersection block.
// Input stream: tuser carries the opcode; tdata carries a map write (cell index and wall bit)
// or a cast (angle, first grid line, player position). A map write updates one cell and
// gives no result; opcode 3 is dropped. A cast gives exactly one result transfer: tuser is
// the hit flag, tdata the hit point (zero on a miss).
// A cast runs 16 CORDIC iterations, then, unless the ray can hit no grid line, two 48-bit
// divisions on a shared restoring divider, then the cell lookup through the registered map
// read port (states CELL_A, CELL_B, CELL_C) for each grid line stepped.
// Casts are handled one at a time; input ready is high only while the controller is idle.
// A finished result sits in the output register, so the next item is accepted while it
// waits; a stalled receiver holds up only the next cast's result stage.
// After reset the wall map is cleared one cell a cycle over all MAP_CELLS cells, with no input
// accepted. Configuration writes on cfg_we/cfg_addr/cfg_wdata are taken at any time and
// should be issued only while the block is idle.
`default_nettype none
module grid_ray_wall_intersection #(
    parameter int MAP_CELLS  = 4096,
    parameter int CELL_UNITS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [10:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // cell_index[11:0], cell_is_wall[12], ray_angle[28:13], start_line[49:29],
    // player_x[69:50], player_y[89:70], zero fill
    input  wire logic [95:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit_x[20:0], hit_y[41:21], zero fill
    output logic [47:0]       m_axis_tdata,
    // hit[0]
    output logic              m_axis_tuser
);
    localparam int ADDR_W = $clog2(MAP_CELLS);
    localparam int CNT_W  = (ADDR_W > 6) ? ADDR_W : 6;

    grwi_pkg::cmd_t    cmd;
    grwi_pkg::status_t status;
    logic [CNT_W-1:0]  cnt;
    logic signed [20:0] hit_x, hit_y;

    grwi_ctrl #(
        .MAP_CELLS (MAP_CELLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd),
        .cnt       (cnt)
    );

    grwi_dp #(
        .MAP_CELLS  (MAP_CELLS),
        .CELL_UNITS (CELL_UNITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cnt          (cnt),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .opcode       (s_axis_tuser),
        .cell_index   (s_axis_tdata[11:0]),
        .cell_is_wall (s_axis_tdata[12]),
        .ray_angle    ($signed(s_axis_tdata[28:13])),
        .start_line   ($signed(s_axis_tdata[49:29])),
        .player_x     (s_axis_tdata[69:50]),
        .player_y     (s_axis_tdata[89:70]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_hit      (m_axis_tuser),
        .out_hit_x    (hit_x),
        .out_hit_y    (hit_y)
    );

    assign m_axis_tdata = {6'd0, hit_y, hit_x};

endmodule
`default_nettype wire
